// File: rtl/seu_pkg.sv
// Shared types and constants for the string literal escape decoder.
// Used by seu_front, seu_queue, seu_back and string_escape_unescape_utf8.
`timescale 1ns / 1ps
`default_nettype none

package seu_pkg;

    // decoder modes; code 7 is unused and decodes as plain text
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX    = 3'd2,
        MODE_OCT    = 3'd3,
        MODE_USTART = 3'd4,
        MODE_USHORT = 3'd5,
        MODE_UBRACE = 3'd6
    } seu_mode_t;

    // characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_U      = 8'h75;

    // control bytes
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_FF  = 8'h0C;

    // UTF-8 patterns
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;
    localparam logic [7:0] UTF8_ASCII = 8'h7F;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } seu_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_last;
    } seu_out_t;

    // work record handed from the front to the back
    typedef struct packed {
        logic        enc_valid;  // a value to emit
        logic        enc_utf8;   // 1: encode value as UTF-8, 0: emit low byte raw
        logic [31:0] enc_value;
        logic        tail_valid; // a plain byte after the encoded value
        logic [7:0]  tail_byte;
        logic        last;
    } seu_rec_t;

endpackage

`default_nettype wire

// File: rtl/seu_front.sv
// Front end: escape state machine that classifies each input byte into a work record.
// Depends on seu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module seu_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire seu_pkg::seu_in_t item,
    input  wire logic             accept,
    output seu_pkg::seu_rec_t     rec,
    output logic                  rec_push
);
    import seu_pkg::*;

    seu_mode_t   mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;

    logic [7:0]  c;
    logic        hv;
    logic [3:0]  hd;
    logic        is_oct;
    logic [15:0] su_acc;
    logic [1:0]  su_cnt;
    logic [7:0]  hex8;
    logic [7:0]  oct8;
    logic [15:0] su16;

    assign c = item.in_byte;

    always_comb
    begin
        hv = 1'b1;
        hd = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hd = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hd = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hd = 4'(c - 8'h37);
        end
        else
        begin
            hv = 1'b0;
        end
    end

    assign is_oct = (c >= 8'h30) && (c <= 8'h37);
    assign hex8   = {acc_reg[3:0], hd};
    assign oct8   = {acc_reg[4:0], (is_oct ? c[2:0] : 3'd0)};
    assign su_acc = (mode_reg == MODE_USTART) ? 16'd0 : acc_reg[15:0];
    assign su_cnt = (mode_reg == MODE_USTART) ? 2'd0 : cnt_reg;
    assign su16   = {su_acc[11:0], hd};

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rec       = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                cnt_next  = 2'd0;
                acc_next  = 32'd0;
                rec.enc_valid = 1'b1;
                case (c)
                    CH_N:      rec.enc_value = {24'd0, CTL_LF};
                    CH_R:      rec.enc_value = {24'd0, CTL_CR};
                    CH_A:      rec.enc_value = {24'd0, CTL_BEL};
                    CH_B:      rec.enc_value = {24'd0, CTL_BS};
                    CH_T:      rec.enc_value = {24'd0, CTL_TAB};
                    CH_F:      rec.enc_value = {24'd0, CTL_FF};
                    CH_BSLASH: rec.enc_value = {24'd0, CH_BSLASH};
                    CH_X:
                    begin
                        rec.enc_valid = 1'b0;
                        mode_next     = MODE_HEX;
                    end
                    CH_U:
                    begin
                        rec.enc_valid = 1'b0;
                        mode_next     = MODE_USTART;
                    end
                    default:
                    begin
                        if (is_oct)
                        begin
                            rec.enc_valid = 1'b0;
                            mode_next     = MODE_OCT;
                            acc_next      = {29'd0, c[2:0]};
                            cnt_next      = 2'd1;
                        end
                        else
                        begin
                            rec.enc_value = {24'd0, c};
                        end
                    end
                endcase
            end
            MODE_HEX:
            begin
                if (cnt_reg >= 2'd1)
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_value = {24'd0, hex8};
                    mode_next     = MODE_PLAIN;
                    cnt_next      = 2'd0;
                    acc_next      = 32'd0;
                end
                else
                begin
                    acc_next = {24'd0, hex8};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            MODE_OCT:
            begin
                if (cnt_reg >= 2'd2)
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_value = {24'd0, oct8};
                    mode_next     = MODE_PLAIN;
                    cnt_next      = 2'd0;
                    acc_next      = 32'd0;
                end
                else
                begin
                    acc_next = {24'd0, oct8};
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            MODE_USTART, MODE_USHORT:
            begin
                if (mode_reg == MODE_USTART && c == CH_LBRACE)
                begin
                    mode_next = MODE_UBRACE;
                    cnt_next  = 2'd0;
                    acc_next  = 32'd0;
                end
                else if (hv)
                begin
                    if (su_cnt >= 2'd3)
                    begin
                        rec.enc_valid = 1'b1;
                        rec.enc_utf8  = 1'b1;
                        rec.enc_value = {16'd0, su16};
                        mode_next     = MODE_PLAIN;
                        cnt_next      = 2'd0;
                        acc_next      = 32'd0;
                    end
                    else
                    begin
                        mode_next = MODE_USHORT;
                        acc_next  = {16'd0, su16};
                        cnt_next  = su_cnt + 2'd1;
                    end
                end
                else
                begin
                    // end the short form early, then decode this byte as plain text
                    rec.enc_valid = 1'b1;
                    rec.enc_utf8  = 1'b1;
                    rec.enc_value = {16'd0, su_acc};
                    cnt_next      = 2'd0;
                    acc_next      = 32'd0;
                    if (c == CH_BSLASH)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        mode_next      = MODE_PLAIN;
                        rec.tail_valid = 1'b1;
                        rec.tail_byte  = c;
                    end
                end
            end
            MODE_UBRACE:
            begin
                if (hv)
                begin
                    acc_next = {acc_reg[27:0], hd};
                end
                else
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_utf8  = 1'b1;
                    rec.enc_value = acc_reg;
                    mode_next     = MODE_PLAIN;
                    cnt_next      = 2'd0;
                    acc_next      = 32'd0;
                end
            end
            default:
            begin
                mode_next = (c == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
                if (c != CH_BSLASH)
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_value = {24'd0, c};
                end
            end
        endcase

        // flush a sequence still open at the last byte
        if (item.in_last)
        begin
            case (mode_next)
                MODE_HEX, MODE_OCT:
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_utf8  = 1'b0;
                    rec.enc_value = {24'd0, acc_next[7:0]};
                end
                MODE_USTART, MODE_USHORT, MODE_UBRACE:
                begin
                    rec.enc_valid = 1'b1;
                    rec.enc_utf8  = 1'b1;
                    rec.enc_value = acc_next;
                end
                default:
                begin
                end
            endcase
            mode_next = MODE_PLAIN;
            cnt_next  = 2'd0;
            acc_next  = 32'd0;
        end
        rec.last = item.in_last;
    end

    assign rec_push = accept && (rec.enc_valid || rec.tail_valid || item.in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            cnt_reg  <= 2'd0;
            acc_reg  <= 32'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/seu_queue.sv
// Short queue of work records between the front and the back.
// Depends on seu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module seu_queue #(
    parameter int unsigned DEPTH = seu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire seu_pkg::seu_rec_t wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output seu_pkg::seu_rec_t      rd_data,
    output logic                   rd_valid
);
    import seu_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    seu_rec_t      entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign full     = (cnt_reg == FULL_CNT);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/seu_back.sv
// Back end: expands each work record into output bytes in the result register, one per cycle while pop keeps up.
// Depends on seu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module seu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire seu_pkg::seu_rec_t head,
    input  wire logic              head_valid,
    output logic                   head_pop,
    output seu_pkg::seu_out_t      result,
    output logic                   empty,
    input  wire logic              pop
);
    import seu_pkg::*;

    seu_out_t    out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  idx_reg, idx_next;

    logic [31:0] cp;
    logic [2:0]  n_enc, n_tot, last_idx;
    logic        marker;
    logic        load;
    logic [7:0]  enc_byte;

    assign cp = head.enc_value;

    always_comb
    begin
        if (!head.enc_valid)
        begin
            n_enc = 3'd0;
        end
        else if (!head.enc_utf8 || cp[31:7] == '0)
        begin
            n_enc = 3'd1;
        end
        else if (cp[31:11] == '0)
        begin
            n_enc = 3'd2;
        end
        else if (cp[31:16] == '0)
        begin
            n_enc = 3'd3;
        end
        else
        begin
            n_enc = 3'd4;
        end
    end

    assign n_tot    = n_enc + {2'd0, head.tail_valid};
    assign marker   = (n_tot == 3'd0);
    assign last_idx = marker ? 3'd0 : n_tot - 3'd1;

    always_comb
    begin
        case ({n_enc, idx_reg})
            {3'd1, 3'd0}: enc_byte = head.enc_utf8 ? (cp[7:0] & UTF8_ASCII) : cp[7:0];
            {3'd2, 3'd0}: enc_byte = cp[13:6] | UTF8_LEAD2;
            {3'd2, 3'd1}: enc_byte = {2'b00, cp[5:0]} | UTF8_CONT;
            {3'd3, 3'd0}: enc_byte = cp[19:12] | UTF8_LEAD3;
            {3'd3, 3'd1}: enc_byte = {2'b00, cp[11:6]} | UTF8_CONT;
            {3'd3, 3'd2}: enc_byte = {2'b00, cp[5:0]} | UTF8_CONT;
            {3'd4, 3'd0}: enc_byte = cp[25:18] | UTF8_LEAD4;
            {3'd4, 3'd1}: enc_byte = {2'b00, cp[17:12]} | UTF8_CONT;
            {3'd4, 3'd2}: enc_byte = {2'b00, cp[11:6]} | UTF8_CONT;
            {3'd4, 3'd3}: enc_byte = {2'b00, cp[5:0]} | UTF8_CONT;
            default:      enc_byte = 8'd0;
        endcase
    end

    // load a new beat when the result register is free or being drained
    assign load     = head_valid && (!out_valid_reg || pop);
    assign head_pop = load && (idx_reg == last_idx);

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (marker)
            begin
                out_next.out_byte   = 8'd0;
                out_next.byte_valid = 1'b0;
            end
            else
            begin
                out_next.out_byte   = (idx_reg < n_enc) ? enc_byte : head.tail_byte;
                out_next.byte_valid = 1'b1;
            end
            out_next.out_last = head.last && (idx_reg == last_idx);
            idx_next = (idx_reg == last_idx) ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/string_escape_unescape_utf8.sv
// String literal body decoder: escapes and \u code points to UTF-8 bytes.
// Top level; instantiates seu_front, seu_queue and seu_back; depends on seu_pkg.
//
// Usage:
//   Input channel: drive item (in_byte, in_last) with push; a beat is taken
//   at a clock edge where push is high and full is low. Mark the final byte
//   of each literal body with in_last.
//   Result channel: while empty is low, result holds the oldest decoded byte;
//   raise pop to take it. A literal whose last byte yields no data ends with
//   one result that has byte_valid low and out_last high.
// Path: front-end decode (combinational), record queue, back-end result register.
// Throughput: one input byte per cycle while full is low. The back end emits
//   one result per cycle while the result side is not stalled, so an item that
//   expands to more than one byte (UTF-8 sequences, up to four bytes plus one
//   plain byte) holds it for one result per byte; the record queue of
//   QUEUE_DEPTH entries absorbs this and full rises once it fills.
// Reset: clears the decoder to plain text, empties the queue and the result
//   register. A stalled receiver keeps the current result stable and backs
//   pressure up through the queue to full.
`timescale 1ns / 1ps
`default_nettype none

module string_escape_unescape_utf8 #(
    parameter int unsigned QUEUE_DEPTH = seu_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire seu_pkg::seu_in_t  item,
    output logic                   empty,
    input  wire logic              pop,
    output seu_pkg::seu_out_t      result
);
    import seu_pkg::*;

    seu_rec_t front_rec;
    logic     front_push;
    seu_rec_t head;
    logic     head_valid;
    logic     head_pop;
    logic     accept;

    assign accept = push && !full;

    seu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .accept   (accept),
        .rec      (front_rec),
        .rec_push (front_push)
    );

    seu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_rec),
        .full     (full),
        .rd_en    (head_pop),
        .rd_data  (head),
        .rd_valid (head_valid)
    );

    seu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

// File: verif/string_escape_unescape_utf8_tb.sv
// Testbench for the string literal escape decoder with UTF-8 output.
// Drives directed and random literal bodies; checks typed directed rows against fixed results
// and every other result against an in-bench decoder model; depends on seu_pkg and string_escape_unescape_utf8.
`timescale 1ns / 1ps

module string_escape_unescape_utf8_tb;
    import seu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 52;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_7 = 8'h37;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_Q = 8'h71;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [6:0][7:0] SIMPLE_ESC = {CH_N, CH_R, CH_A, CH_B, CH_T, CH_F, CH_BSLASH};
    localparam seu_out_t NO_RESULT = '0;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        seu_out_t   want;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     push = 1'b0;
    logic     pop = 1'b0;
    seu_in_t  item = '0;
    logic     full;
    logic     empty;
    seu_out_t result;

    // decoder model state
    seu_mode_t   dec_mode;
    logic [1:0]  dec_count;
    logic [31:0] dec_acc;
    logic [7:0]  step_bytes[$];
    seu_out_t    step_results[$];
    seu_out_t    expected_bytes[$];

    logic [7:0]  lit_bytes[$];
    dir_row_t    directed_rows[25];

    int          items_sent = 0;
    int          mismatches = 0;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;
    int unsigned cycle_count = 0;

    string_escape_unescape_utf8 DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int hex_value(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c - CH_0);
        if (c >= CH_A && c <= CH_F)
            return int'(c - CH_A) + 10;
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // every byte keeps only its low 8 bits, so huge values fold into the lead
    function automatic void utf8_encode(logic [31:0] cp);
        logic [31:0] lead;
        if (cp <= 32'(UTF8_ASCII))
        begin
            step_bytes.push_back(cp[7:0]);
        end
        else if (cp <= 32'h7FF)
        begin
            lead = (cp >> 6) | 32'(UTF8_LEAD2);
            step_bytes.push_back(lead[7:0]);
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[5:0]});
        end
        else if (cp <= 32'hFFFF)
        begin
            lead = (cp >> 12) | 32'(UTF8_LEAD3);
            step_bytes.push_back(lead[7:0]);
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[11:6]});
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[5:0]});
        end
        else
        begin
            lead = (cp >> 18) | 32'(UTF8_LEAD4);
            step_bytes.push_back(lead[7:0]);
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[17:12]});
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[11:6]});
            step_bytes.push_back(UTF8_CONT | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic void back_to_plain();
        dec_mode = MODE_PLAIN;
        dec_count = '0;
        dec_acc = '0;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        if (c == CH_BSLASH)
            dec_mode = MODE_ESC;
        else
            step_bytes.push_back(c);
    endfunction

    // short \u form: a non-hex char closes it and is decoded again as text
    function automatic void short_u_char(logic [7:0] c);
        int d;
        d = hex_value(c);
        if (d >= 0)
        begin
            dec_acc = ((dec_acc << 4) | 32'(d)) & 32'hFFFF;
            if (dec_count >= 2'd3)
            begin
                utf8_encode(dec_acc);
                back_to_plain();
            end
            else
            begin
                dec_count++;
            end
        end
        else
        begin
            utf8_encode(dec_acc);
            back_to_plain();
            plain_char(c);
        end
    endfunction

    function automatic void decode_literal_byte(logic [7:0] c, logic fin);
        int d;
        step_bytes.delete();
        step_results.delete();
        case (dec_mode)
            MODE_ESC:
            begin
                back_to_plain();
                case (c)
                    CH_N:      step_bytes.push_back(CTL_LF);
                    CH_R:      step_bytes.push_back(CTL_CR);
                    CH_A:      step_bytes.push_back(CTL_BEL);
                    CH_B:      step_bytes.push_back(CTL_BS);
                    CH_T:      step_bytes.push_back(CTL_TAB);
                    CH_F:      step_bytes.push_back(CTL_FF);
                    CH_BSLASH: step_bytes.push_back(CH_BSLASH);
                    CH_X:      dec_mode = MODE_HEX;
                    CH_U:      dec_mode = MODE_USTART;
                    default:
                    begin
                        if (c >= CH_0 && c <= CH_7)
                        begin
                            dec_mode = MODE_OCT;
                            dec_acc = 32'(c - CH_0);
                            dec_count = 2'd1;
                        end
                        else
                        begin
                            step_bytes.push_back(c);
                        end
                    end
                endcase
            end
            MODE_HEX:
            begin
                d = hex_value(c);
                if (d < 0)
                    d = 0;
                dec_acc = ((dec_acc << 4) + 32'(d)) & 32'hFF;
                if (dec_count >= 2'd1)
                begin
                    step_bytes.push_back(dec_acc[7:0]);
                    back_to_plain();
                end
                else
                begin
                    dec_count++;
                end
            end
            MODE_OCT:
            begin
                d = (c >= CH_0 && c <= CH_7) ? int'(c - CH_0) : 0;
                dec_acc = ((dec_acc << 3) + 32'(d)) & 32'hFF;
                if (dec_count >= 2'd2)
                begin
                    step_bytes.push_back(dec_acc[7:0]);
                    back_to_plain();
                end
                else
                begin
                    dec_count++;
                end
            end
            MODE_USTART:
            begin
                dec_acc = '0;
                dec_count = '0;
                if (c == CH_LBRACE)
                begin
                    dec_mode = MODE_UBRACE;
                end
                else
                begin
                    dec_mode = MODE_USHORT;
                    short_u_char(c);
                end
            end
            MODE_USHORT:
                short_u_char(c);
            MODE_UBRACE:
            begin
                d = hex_value(c);
                if (d >= 0)
                begin
                    dec_acc = (dec_acc << 4) + 32'(d);
                end
                else
                begin
                    utf8_encode(dec_acc);
                    back_to_plain();
                end
            end
            default:
            begin
                dec_mode = MODE_PLAIN;
                plain_char(c);
            end
        endcase

        // flush whatever sequence is still open at the end of the literal
        if (fin)
        begin
            case (dec_mode)
                MODE_HEX, MODE_OCT:
                    step_bytes.push_back(dec_acc[7:0]);
                MODE_USTART, MODE_USHORT, MODE_UBRACE:
                    utf8_encode(dec_acc);
                default:
                    ;
            endcase
            back_to_plain();
        end

        foreach (step_bytes[k])
            step_results.push_back('{step_bytes[k], 1'b1, fin && (k == step_bytes.size() - 1)});
        if (fin && step_bytes.size() == 0)
            step_results.push_back('{8'h00, 1'b0, 1'b1});
    endfunction

    function automatic logic [7:0] any_byte();
        logic [31:0] r;
        r = $urandom();
        return r[7:0];
    endfunction

    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10)
            return CH_0 + d[7:0];
        if ($urandom_range(0, 1) == 1)
            return CH_A + d[7:0] - 8'd10;
        return CH_UA + d[7:0] - 8'd10;
    endfunction

    function automatic logic [7:0] oct_char();
        logic [31:0] r;
        r = $urandom_range(0, 7);
        return CH_0 + r[7:0];
    endfunction

    // mostly well-formed escapes with random content, some noise
    task automatic add_segment();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0:
                lit_bytes.push_back(any_byte());
            1:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(SIMPLE_ESC[3'($urandom_range(0, 6))]);
            end
            2:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(CH_X);
                repeat (2)
                    lit_bytes.push_back(($urandom_range(0, 4) == 0) ? any_byte() : hex_char());
            end
            3:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(oct_char());
                repeat (2)
                    lit_bytes.push_back(($urandom_range(0, 4) == 0) ? any_byte() : oct_char());
            end
            4:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(CH_U);
                n = $urandom_range(0, 4);
                repeat (n)
                    lit_bytes.push_back(hex_char());
                if (n == 0 || (n < 4 && $urandom_range(0, 1) == 1))
                    lit_bytes.push_back(any_byte());
            end
            5, 6:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(CH_U);
                lit_bytes.push_back(CH_LBRACE);
                n = $urandom_range(0, 9);
                repeat (n)
                    lit_bytes.push_back(hex_char());
                lit_bytes.push_back(($urandom_range(0, 9) < 7) ? CH_RBRACE : any_byte());
            end
            7:
            begin
                lit_bytes.push_back(CH_BSLASH);
                lit_bytes.push_back(any_byte());
            end
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    lit_bytes.push_back(8'($urandom_range(32, 126)));
            end
        endcase
    endtask

    // offer one beat, hold it until taken, then queue what it should produce
    task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
                             input seu_out_t want);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{c, fin};
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        decode_literal_byte(c, fin);
        if (typed)
        begin
            expected_bytes.push_back(want);
        end
        else
        begin
            foreach (step_results[k])
                expected_bytes.push_back(step_results[k]);
        end
    endtask

    task automatic check_result(input seu_out_t got);
        seu_out_t want;
        if (expected_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: byte %h valid %b last %b",
                         got.out_byte, got.byte_valid, got.out_last);
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
            || got.out_last !== want.out_last)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected byte %h valid %b last %b, got byte %h valid %b last %b",
                         want.out_byte, want.byte_valid, want.out_last,
                         got.out_byte, got.byte_valid, got.out_last);
        end
    endtask

    // result side: random pops, plus one long hold-off to fill the block up
    initial
    begin : rx_side
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held && items_sent >= 40)
            begin
                held = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
            @(posedge clk);
            if (pop && !empty)
                check_result(result);
        end
    end

    initial
    begin : tx_side
        int nseg;
        int cut;

        directed_rows = '{
            '{8'h41,     1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},
            '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
            '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_N,      1'b0, 1'b1, '{CTL_LF, 1'b1, 1'b0}},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_Q,      1'b0, 1'b1, '{CH_Q, 1'b1, 1'b0}},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_X,      1'b0, 1'b0, NO_RESULT},
            '{8'h34,     1'b0, 1'b0, NO_RESULT},
            '{8'h67,     1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_7,      1'b0, 1'b0, NO_RESULT},
            '{CH_7,      1'b0, 1'b0, NO_RESULT},
            '{CH_7,      1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_U,      1'b0, 1'b0, NO_RESULT},
            '{CH_0,      1'b0, 1'b0, NO_RESULT},
            '{CH_0,      1'b0, 1'b0, NO_RESULT},
            '{8'h65,     1'b0, 1'b0, NO_RESULT},
            '{CH_9,      1'b0, 1'b0, NO_RESULT},
            '{CH_BSLASH, 1'b0, 1'b0, NO_RESULT},
            '{CH_U,      1'b0, 1'b0, NO_RESULT},
            // open braced code point at the end flushes as a zero byte
            '{CH_LBRACE, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
            // lone trailing backslash yields only the empty end marker
            '{CH_BSLASH, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
        };

        back_to_plain();
        send_gap_pct = 7;
        recv_gap_pct = 73;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                      directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct = (phase == 0) ? 7 : (phase == 1) ? 73 : 0;
            recv_gap_pct = (phase == 0) ? 73 : (phase == 1) ? 7 : 0;
            while (items_sent < $size(directed_rows) + (phase + 1) * RANDOM_PER_PHASE)
            begin
                lit_bytes.delete();
                nseg = $urandom_range(1, 4);
                repeat (nseg)
                    add_segment();
                // cut some literals short so sequences end while still open
                if ($urandom_range(0, 99) < 20)
                begin
                    cut = $urandom_range(1, lit_bytes.size());
                    while (lit_bytes.size() > cut)
                        void'(lit_bytes.pop_back());
                end
                foreach (lit_bytes[i])
                    send_byte(lit_bytes[i], i == lit_bytes.size() - 1, 1'b0, NO_RESULT);
            end
        end
        push <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
